FILE: rtl/fl32_pkg.sv
// ----------------------------------------------------------------------------
// fl32_pkg: shared types and helpers for the byte-wide Fletcher-32 block
// Widths of the running sums and block counter, the hand-off records between
// the accumulator and the finishing pipeline, and the 16-bit end-around fold.
// ----------------------------------------------------------------------------
package fl32_pkg;

  localparam int DataW = 8;   // message byte
  localparam int SumW  = 32;  // running sums, wrap mod 2^32
  localparam int CntW  = 9;   // words since last block fold
  localparam int ResW  = 32;  // checksum

  // Message tail handed to the finishing pipeline on the last byte
  typedef struct packed {
    logic [SumW-1:0]  first_sum;
    logic [SumW-1:0]  second_sum;
    logic             fold_first;  // partial block still to fold
    logic             add_byte;    // odd trailing byte still to add
    logic [DataW-1:0] data_byte;
  } tail_t;

  // Accumulator status, for checking
  typedef struct packed {
    logic            high_pending;
    logic [CntW-1:0] words_in_block;
  } status_t;

  // Low 16 bits plus the bits above 16
  function automatic logic [SumW-1:0] fold16(input logic [SumW-1:0] v);
    logic [SumW-1:0] lo;
    logic [SumW-1:0] hi;
    lo = {16'h0000, v[15:0]};
    hi = {16'h0000, v[31:16]};
    return lo + hi;
  endfunction

endpackage

FILE: rtl/fletcher32_byte_checksum.sv
// ----------------------------------------------------------------------------
// fletcher32_byte_checksum: streaming Fletcher-32 over a byte message
// Byte stream in, one 32-bit checksum beat out per message.
// ----------------------------------------------------------------------------
// Feed the message one byte per beat on s_axis, tlast on the final byte; one
// checksum beat comes out on m_axis per message. Bytes pair into 16-bit words,
// high byte first. Both sums start at 0xffff, each word adds into the first
// sum and the first into the second, and both fold (low 16 plus high part)
// after every BlockWords words. On the last byte any partial block folds, an
// odd trailing byte adds as a high byte, and a final fold follows; the result
// is second sum in the upper half ORed with the first sum (its bit 16 may be
// set). The block takes one byte every cycle, back to back, across message
// boundaries: the word accumulator updates in the cycle after a byte lands in
// the input register. After the last byte is accepted, the message passes
// tail capture, partial-block fold, trailing byte and final fold into the
// result register; each stage moves on independently, so bytes keep flowing
// while a checksum beat waits to be taken, and only a last byte stalls, once
// all finishing stages hold a message.
// ----------------------------------------------------------------------------
module fletcher32_byte_checksum
  import fl32_pkg::*;
#(
  parameter int BlockWords = 359  // words between folds, 1 to 359
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // [7:0] data_byte
  input  logic            s_axis_tlast_i,   // last_byte
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [ResW-1:0] m_axis_tdata_o    // [31:0] checksum
);

  localparam logic [CntW-1:0] BlockWordsC = CntW'(BlockWords);

  logic    tail_valid;
  logic    tail_ready;
  tail_t   tail;
  status_t status;

  // word pairing, running sums and block folds
  fl32_accum #(
    .BlockWords (BlockWordsC)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .tail_valid_o (tail_valid),
    .tail_ready_i (tail_ready),
    .tail_o       (tail),
    .status_o     (status)
  );

  // completion of a message and the result register
  fl32_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tail_valid_i (tail_valid),
    .tail_ready_o (tail_ready),
    .tail_i       (tail),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

`ifndef SYNTH
  // block counter always restarts before reaching the block length
  a_words_below_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.words_in_block < BlockWordsC)
    else $error("block counter reached block length");

  // handing over a message tail leaves the accumulator at its reset state
  a_tail_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid && tail_ready |=> !status.high_pending && status.words_in_block == '0)
    else $error("accumulator not cleared after message end");

  // an odd trailing byte only arises with no high byte held
  a_trailing_byte_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid && tail.add_byte |-> !status.high_pending)
    else $error("trailing byte flagged while a high byte is held");
`endif

endmodule

FILE: rtl/fl32_accum.sv
// ----------------------------------------------------------------------------
// fl32_accum: input register and running-sum accumulator
// Pairs bytes into words, keeps both sums and the block counter, and hands
// the state of a finished message to the finishing pipeline.
// ----------------------------------------------------------------------------
module fl32_accum
  import fl32_pkg::*;
#(
  parameter logic [CntW-1:0] BlockWords = 9'd359
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] in_byte_i,
  input  logic             in_last_i,
  output logic             tail_valid_o,
  input  logic             tail_ready_i,
  output tail_t            tail_o,
  output status_t          status_o
);

  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             in_last_q;
  logic             upd_go;

  logic [SumW-1:0]  first_sum_q,  first_sum_d;
  logic [SumW-1:0]  second_sum_q, second_sum_d;
  logic [DataW-1:0] held_high_q,  held_high_d;
  logic             pending_q,    pending_d;
  logic [CntW-1:0]  words_q,      words_d;

  logic [SumW-1:0]  word;
  logic [SumW-1:0]  s1_add, s2_add;
  logic [CntW-1:0]  words_inc;
  logic             block_hit;
  logic [SumW-1:0]  s1_blk, s2_blk;
  logic [CntW-1:0]  words_blk;

  // last beat needs room downstream, others never wait
  assign upd_go     = in_valid_q && (!in_last_q || tail_ready_i);
  assign in_ready_o = !in_valid_q || upd_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // word completion path: add, accumulate, block fold
  always_comb begin
    word      = {16'h0000, held_high_q, in_byte_q};
    s1_add    = first_sum_q + word;
    s2_add    = second_sum_q + s1_add;
    words_inc = words_q + CntW'(1);
    block_hit = (words_inc >= BlockWords);
    s1_blk    = block_hit ? fold16(s1_add) : s1_add;
    s2_blk    = block_hit ? fold16(s2_add) : s2_add;
    words_blk = block_hit ? '0 : words_inc;
  end

  always_comb begin
    first_sum_d  = first_sum_q;
    second_sum_d = second_sum_q;
    held_high_d  = held_high_q;
    pending_d    = pending_q;
    words_d      = words_q;

    tail_o.first_sum  = s1_blk;
    tail_o.second_sum = s2_blk;
    tail_o.fold_first = (words_blk != '0);
    tail_o.add_byte   = 1'b0;
    tail_o.data_byte  = in_byte_q;

    if (!pending_q) begin
      tail_o.first_sum  = first_sum_q;
      tail_o.second_sum = second_sum_q;
      tail_o.fold_first = (words_q != '0);
      tail_o.add_byte   = 1'b1;
    end

    if (upd_go) begin
      if (in_last_q) begin
        first_sum_d  = 32'h0000_ffff;
        second_sum_d = 32'h0000_ffff;
        held_high_d  = '0;
        pending_d    = 1'b0;
        words_d      = '0;
      end else if (pending_q) begin
        first_sum_d  = s1_blk;
        second_sum_d = s2_blk;
        held_high_d  = '0;
        pending_d    = 1'b0;
        words_d      = words_blk;
      end else begin
        held_high_d  = in_byte_q;
        pending_d    = 1'b1;
      end
    end
  end

  assign tail_valid_o = in_valid_q && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sum_q  <= 32'h0000_ffff;
      second_sum_q <= 32'h0000_ffff;
      held_high_q  <= '0;
      pending_q    <= 1'b0;
      words_q      <= '0;
    end else begin
      first_sum_q  <= first_sum_d;
      second_sum_q <= second_sum_d;
      held_high_q  <= held_high_d;
      pending_q    <= pending_d;
      words_q      <= words_d;
    end
  end

  assign status_o.high_pending   = pending_q;
  assign status_o.words_in_block = words_q;

endmodule

FILE: rtl/fl32_finish.sv
// ----------------------------------------------------------------------------
// fl32_finish: message completion pipeline and result register
// Partial-block fold, odd trailing byte, final fold and packing, one short
// step per stage; each stage moves on when the next has room.
// ----------------------------------------------------------------------------
module fl32_finish
  import fl32_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tail_valid_i,
  output logic            tail_ready_o,
  input  tail_t           tail_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ResW-1:0] out_data_o
);

  // stage 1: captured tail
  logic             v1_q;
  tail_t            t1_q;
  // stage 2: after partial-block fold
  logic             v2_q;
  logic [SumW-1:0]  s1_2_q, s2_2_q;
  logic             add_2_q;
  logic [DataW-1:0] byte_2_q;
  // stage 3: after trailing byte
  logic             v3_q;
  logic [SumW-1:0]  s1_3_q, s2_3_q;
  // result register
  logic             vo_q;
  logic [ResW-1:0]  res_q;

  logic rdy1, rdy2, rdy3, rdyo;

  logic [SumW-1:0] s1_2_d, s2_2_d, s1_3_d, s2_3_d, f1, f2;
  logic [ResW-1:0] res_d;

  assign rdyo = !vo_q || out_ready_i;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_comb begin
    s1_2_d = t1_q.fold_first ? fold16(t1_q.first_sum)  : t1_q.first_sum;
    s2_2_d = t1_q.fold_first ? fold16(t1_q.second_sum) : t1_q.second_sum;
    s1_3_d = add_2_q ? s1_2_q + {16'h0000, byte_2_q, 8'h00} : s1_2_q;
    s2_3_d = add_2_q ? s2_2_q + s1_3_d : s2_2_q;
    f1     = fold16(s1_3_q);
    f2     = fold16(s2_3_q);
    // bit 16 of the folded first sum lands in the result as it stands
    res_d  = {f2[15:0], 16'h0000} | f1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= tail_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && tail_valid_i) begin
      t1_q <= tail_i;
    end
    if (rdy2 && v1_q) begin
      s1_2_q   <= s1_2_d;
      s2_2_q   <= s2_2_d;
      add_2_q  <= t1_q.add_byte;
      byte_2_q <= t1_q.data_byte;
    end
    if (rdy3 && v2_q) begin
      s1_3_q <= s1_3_d;
      s2_3_q <= s2_3_d;
    end
    if (rdyo && v3_q) begin
      res_q <= res_d;
    end
  end

  assign tail_ready_o = rdy1;
  assign out_valid_o  = vo_q;
  assign out_data_o   = res_q;

endmodule
